// ----- rtl/saed_pkg.sv -----
package saed_pkg;

   localparam int MAX_LINE_DEFAULT = 16384;
   localparam int PIXEL_W          = 8;
   localparam int LINE_WIDTH_W     = 15;
   localparam int PAGE_HEIGHT_W    = 16;
   localparam int CSR_INDEX_W      = 8;
   localparam int CSR_DATA_W       = 16;
   localparam int STORE_W          = 9;
   localparam int AHEAD_W          = 6;
   localparam int ERR_W            = 5;
   localparam int SUM_W            = 10;
   localparam int DIV_SHIFT        = 3;
   localparam int ROLES            = 2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_LINE_WIDTH  = csr_index_type'(0);
   localparam csr_index_type CSR_PAGE_HEIGHT = csr_index_type'(1);

   localparam logic signed [SUM_W-1:0] DOT_THRESHOLD = SUM_W'(128);
   localparam logic signed [SUM_W-1:0] DOT_LEVEL     = SUM_W'(255);
   localparam logic signed [SUM_W-1:0] DIV_BIAS      = SUM_W'((1 << DIV_SHIFT) - 1);

   typedef enum logic {
      ROLE_0,
      ROLE_1
   } role_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row0;
      logic               first;
      logic               last;
      role_type           role;
   } stage_type;

   function automatic role_type next_role(input role_type r);
      case (r)
         ROLE_0:  return ROLE_1;
         default: return ROLE_0;
      endcase
   endfunction

   function automatic logic signed [ERR_W-1:0] diffuse_err(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] diff;
      logic signed [SUM_W-1:0] biased;
      diff   = (sum >= DOT_THRESHOLD) ? sum - DOT_LEVEL : sum;
      biased = diff[SUM_W-1] ? diff + DIV_BIAS : diff;
      return ERR_W'(biased >>> DIV_SHIFT);
   endfunction

endpackage

// ----- rtl/serpentine_atkinson_error_diffusion_core.sv -----
// Pipeline: an accepted request is registered with its row-store read, then its dot is registered
// onto rsp once the rsp register is free (one row-store read stage, one diffusion stage).
// Throughput: one request per cycle while rsp is not stalled, set by the registered forward error loop
// and one read and one write port on each of the two row stores.
// Reset: synchronous; line width and page height to 1, position and forward errors cleared.
// Row stores are never swept: the first row of each page masks them and rewrites them.
module serpentine_atkinson_error_diffusion_core #(
   parameter int MAX_LINE = saed_pkg::MAX_LINE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [saed_pkg::PIXEL_W-1:0]     req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_dot,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [saed_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [saed_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W  = $clog2(MAX_LINE);
   localparam int WIDTH_W = $clog2(MAX_LINE + 1);
   localparam int CMP_W   = (WIDTH_W > saed_pkg::LINE_WIDTH_W) ? WIDTH_W : saed_pkg::LINE_WIDTH_W;
   localparam int SW      = saed_pkg::STORE_W;
   localparam int HW      = saed_pkg::PAGE_HEIGHT_W;

   logic [saed_pkg::LINE_WIDTH_W-1:0] line_width_ff, line_width_in;
   logic [HW-1:0]                     page_height_ff, page_height_in;
   logic [ADDR_W-1:0]                 col_ff, col_in;
   logic [HW-1:0]                     row_ff, row_in;
   saed_pkg::role_type                role_ff, role_in;
   logic                              s1_valid_ff, s1_valid_in;
   saed_pkg::stage_type               s1_ff, s1_in;
   logic [ADDR_W-1:0]                 s1_x_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_dot_ff;
   logic signed [saed_pkg::AHEAD_W-1:0] near_ff, near_in;
   logic signed [saed_pkg::AHEAD_W-1:0] far_ff, far_in;
   logic signed [SW-1:0]              partial_ff;
   logic [ADDR_W-1:0]                 prev_x_ff;
   logic signed [SW-1:0]              carry_a_ff;
   logic signed [SW-1:0]              carry_b_ff;

   logic [CMP_W-1:0]   lw_ext;
   logic [WIDTH_W-1:0] eff_w;
   logic [HW-1:0]      eff_h;
   logic               advance;
   logic               accept;
   logic               csr_fire;
   logic [WIDTH_W-1:0] col_next;
   logic               row_end;
   logic [HW:0]        row_inc;
   logic               page_end;
   logic [ADDR_W-1:0]  x;

   logic [SW-1:0]        rd_data [saed_pkg::ROLES];
   logic                 wr_en   [saed_pkg::ROLES];
   logic [ADDR_W-1:0]    wr_addr [saed_pkg::ROLES];
   logic [SW-1:0]        wr_data [saed_pkg::ROLES];

   logic signed [SW-1:0]                a_raw, b_raw, a_val, b_val;
   logic signed [saed_pkg::SUM_W-1:0]   sum;
   logic                                dot;
   logic signed [saed_pkg::ERR_W-1:0]   err;
   logic signed [SW-1:0]                err_ext;
   logic signed [SW-1:0]                final_prev;
   logic signed [SW-1:0]                final_last;
   logic                                b_we;

   always_comb begin
      lw_ext = CMP_W'(line_width_ff);
      if (lw_ext == '0) begin
         eff_w = WIDTH_W'(1);
      end else if (lw_ext > CMP_W'(MAX_LINE)) begin
         eff_w = WIDTH_W'(MAX_LINE);
      end else begin
         eff_w = WIDTH_W'(lw_ext);
      end
      eff_h = (page_height_ff == '0) ? HW'(1) : page_height_ff;
   end

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign col_next = WIDTH_W'(col_ff) + WIDTH_W'(1);
   assign row_end  = col_next >= eff_w;
   assign row_inc  = {1'b0, row_ff} + (HW + 1)'(1);
   assign page_end = row_inc >= {1'b0, eff_h};
   assign x        = row_ff[0] ? ADDR_W'(eff_w - WIDTH_W'(1) - WIDTH_W'(col_ff)) : col_ff;

   always_comb begin
      line_width_in  = line_width_ff;
      page_height_in = page_height_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      role_in        = role_ff;
      if (csr_fire) begin
         case (csr_index)
            saed_pkg::CSR_LINE_WIDTH:  line_width_in  = saed_pkg::LINE_WIDTH_W'(csr_wdata);
            saed_pkg::CSR_PAGE_HEIGHT: page_height_in = HW'(csr_wdata);
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (row_end) begin
            col_in  = '0;
            row_in  = page_end ? '0 : HW'(row_inc);
            role_in = saed_pkg::next_role(role_ff);
         end else begin
            col_in = ADDR_W'(col_next);
         end
      end
   end

   always_comb begin
      s1_in.pixel = req_pixel;
      s1_in.row0  = (row_ff == '0);
      s1_in.first = (col_ff == '0);
      s1_in.last  = row_end;
      s1_in.role  = role_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   for (genvar g = 0; g < saed_pkg::ROLES; g++) begin : g_row
      saed_ram #(
         .WIDTH (SW),
         .DEPTH (MAX_LINE)
      ) u_row (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr[g]),
         .wr_data (wr_data[g]),
         .rd_en   (accept),
         .rd_addr (x),
         .rd_data (rd_data[g])
      );
   end

   always_comb begin
      case (s1_ff.role)
         saed_pkg::ROLE_1: begin
            a_raw = rd_data[1];
            b_raw = rd_data[0];
         end
         default: begin
            a_raw = rd_data[0];
            b_raw = rd_data[1];
         end
      endcase
      if (s1_ff.row0) begin
         a_val = '0;
         b_val = '0;
      end else if (s1_ff.first) begin
         a_val = carry_a_ff;
         b_val = carry_b_ff;
      end else begin
         a_val = a_raw;
         b_val = b_raw;
      end
      sum        = $signed({2'b00, s1_ff.pixel}) + saed_pkg::SUM_W'(a_val)
                   + saed_pkg::SUM_W'(near_ff);
      dot        = sum >= saed_pkg::DOT_THRESHOLD;
      err        = saed_pkg::diffuse_err(sum);
      err_ext    = SW'(err);
      final_prev = partial_ff + SW'(near_ff) + err_ext;
      final_last = b_val + SW'(far_ff) + err_ext;
      b_we       = advance && !s1_ff.first;
      if (s1_ff.last || csr_fire) begin
         near_in = '0;
         far_in  = '0;
      end else begin
         near_in = far_ff + saed_pkg::AHEAD_W'(err);
         far_in  = saed_pkg::AHEAD_W'(err);
      end
   end

   // the current row's store takes the errors for two rows down once each entry is consumed
   always_comb begin
      for (int i = 0; i < saed_pkg::ROLES; i++) begin
         wr_en[i]   = 1'b0;
         wr_addr[i] = '0;
         wr_data[i] = '0;
      end
      case (s1_ff.role)
         saed_pkg::ROLE_1: begin
            wr_en[0]   = b_we;
            wr_addr[0] = prev_x_ff;
            wr_data[0] = final_prev;
            wr_en[1]   = advance;
            wr_addr[1] = s1_x_ff;
            wr_data[1] = err_ext;
         end
         default: begin
            wr_en[1]   = b_we;
            wr_addr[1] = prev_x_ff;
            wr_data[1] = final_prev;
            wr_en[0]   = advance;
            wr_addr[0] = s1_x_ff;
            wr_data[0] = err_ext;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= saed_pkg::LINE_WIDTH_W'(1);
         page_height_ff <= HW'(1);
         col_ff         <= '0;
         row_ff         <= '0;
         role_ff        <= saed_pkg::ROLE_0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         near_ff        <= '0;
         far_ff         <= '0;
      end else begin
         line_width_ff  <= line_width_in;
         page_height_ff <= page_height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         role_ff        <= role_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance || csr_fire) begin
            near_ff <= near_in;
            far_ff  <= far_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff   <= s1_in;
         s1_x_ff <= x;
      end
      if (advance) begin
         rsp_dot_ff <= dot;
         partial_ff <= b_val;
         prev_x_ff  <= s1_x_ff;
         if (s1_ff.last) begin
            carry_a_ff <= final_last;
            carry_b_ff <= err_ext;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dot   = rsp_dot_ff;

`ifndef SYNTH
   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      WIDTH_W'(col_ff) < eff_w)
      else $error("column position beyond line edge");

   a_row_in_page: assert property (@(posedge clock) disable iff (reset)
      row_ff < eff_h)
      else $error("row position beyond page end");

   a_accept_needs_room: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff) |-> advance)
      else $error("request accepted over an occupied diffusion stage");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("response raised without a stage advance");
`endif

endmodule

// ----- rtl/saed_ram.sv -----
module saed_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/saed_dot_checker.sv -----
module saed_dot_checker
   import saed_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_dot,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     dots_outstanding
);

   logic [LINE_WIDTH_W-1:0]  line_width;
   logic [PAGE_HEIGHT_W-1:0] page_height;

   int err_this_row [MAX_LINE];
   int err_next_row [MAX_LINE];
   int err_second_row [MAX_LINE];
   int err_ahead_near;
   int err_ahead_far;
   int column_pos;
   int row_pos;

   bit dots_due [$];

   function automatic int active_width();
      if (line_width == 0) return 1;
      if (line_width > MAX_LINE) return MAX_LINE;
      return int'(line_width);
   endfunction

   function automatic int active_height();
      return (page_height == 0) ? 1 : int'(page_height);
   endfunction

   function automatic void restart_page(input int span);
      for (int i = 0; i < span; i++) begin
         err_this_row[i]   = 0;
         err_next_row[i]   = 0;
         err_second_row[i] = 0;
      end
      err_ahead_near = 0;
      err_ahead_far  = 0;
      column_pos     = 0;
      row_pos        = 0;
   endfunction

   function automatic bit diffuse_pixel(input logic [PIXEL_W-1:0] pixel);
      int w;
      int h;
      int x;
      int pix;
      int sum;
      int err;
      bit dot;
      w   = active_width();
      h   = active_height();
      pix = int'(pixel);
      if (column_pos >= w) column_pos = 0;
      if (row_pos >= h) row_pos = 0;
      x   = (row_pos % 2 == 0) ? column_pos : w - 1 - column_pos;
      sum = pix + err_this_row[x] + err_ahead_near;
      dot = (sum >= 128);
      err = (sum - (dot ? 255 : 0)) / 8;
      err_ahead_near = err_ahead_far + err;
      err_ahead_far  = err;
      if (row_pos + 1 < h) begin
         for (int k = -1; k <= 1; k++) begin
            if (x + k >= 0 && x + k < w) err_next_row[x + k] += err;
         end
      end
      if (row_pos + 2 < h) err_second_row[x] += err;
      column_pos++;
      if (column_pos >= w) begin
         column_pos     = 0;
         err_ahead_near = 0;
         err_ahead_far  = 0;
         if (row_pos + 1 >= h) begin
            restart_page(w);
         end else begin
            row_pos++;
            for (int i = 0; i < w; i++) begin
               err_this_row[i]   = err_next_row[i];
               err_next_row[i]   = err_second_row[i];
               err_second_row[i] = 0;
            end
         end
      end
      return dot;
   endfunction

   always @(posedge clock) begin
      bit want;
      bit due;
      if (reset) begin
         line_width  = LINE_WIDTH_W'(1);
         page_height = PAGE_HEIGHT_W'(1);
         restart_page(MAX_LINE);
         dots_due.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (dots_due.size() == 0) begin
               mismatches++;
               $display("%0t: dot with no request outstanding: expected none, actual %0b",
                        $time, rsp_dot);
            end else begin
               want = dots_due.pop_front();
               if (rsp_dot !== want) begin
                  mismatches++;
                  $display("%0t: dot mismatch: expected %0b, actual %0b", $time, want, rsp_dot);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINE_WIDTH: begin
                  line_width = csr_wdata[LINE_WIDTH_W-1:0];
               end
               CSR_PAGE_HEIGHT: begin
                  page_height = csr_wdata[PAGE_HEIGHT_W-1:0];
               end
               default: begin
               end
            endcase
            restart_page(MAX_LINE);
         end
         if (req_valid && !req_stall) begin
            due      = diffuse_pixel(req_pixel);
            dots_due = {dots_due, due};
         end
      end
      dots_outstanding = dots_due.size();
   end

endmodule

// ----- tb/tb_serpentine_atkinson_error_diffusion_core.sv -----
module tb_serpentine_atkinson_error_diffusion_core;
   import saed_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_dot;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_LINE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches;
   int dots_outstanding;
   int send_idle_pct = 14;
   int recv_idle_pct = 55;
   bit hold_req = 1'b0;
   int cycle_count = 0;

   serpentine_atkinson_error_diffusion_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_dot   (rsp_dot),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   saed_dot_checker u_dot_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dot          (rsp_dot),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .dots_outstanding (dots_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // hold off once for a long stretch, otherwise stall at random
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      int r;
      r = $urandom_range(99);
      if (r < 15) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      if (r < 30) return PIXEL_W'($urandom_range(135, 120));
      return PIXEL_W'($urandom_range(255));
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pixel;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (dots_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [PIXEL_W-1:0] opening [0:13];
      logic [CSR_DATA_W-1:0] width_data;
      logic [CSR_DATA_W-1:0] height_data;
      int requests;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-pixel page after reset
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd127);
      send_pixel(8'd128);

      // serpentine rows, row ends and a page end on a 3 by 4 page
      write_csr(CSR_LINE_WIDTH, CSR_DATA_W'(3));
      write_csr(CSR_PAGE_HEIGHT, CSR_DATA_W'(4));
      opening = '{8'd200, 8'd100, 8'd130, 8'd60, 8'd255, 8'd0, 8'd127,
                  8'd128, 8'd90, 8'd250, 8'd10, 8'd140, 8'd70, 8'd180};
      foreach (opening[i]) send_pixel(opening[i]);

      // unknown index mid-page restarts the page
      write_csr(csr_index_type'(2), 16'hFFFF);
      send_pixel(8'd129);
      send_pixel(8'd66);

      // zero width and zero height, with bit 15 masked off the width
      write_csr(CSR_LINE_WIDTH, 16'h8000);
      write_csr(CSR_PAGE_HEIGHT, 16'h0000);
      send_pixel(8'd131);
      send_pixel(8'd64);
      send_pixel(8'd200);

      for (int s = 0; s < 15; s++) begin
         if (s < 5) begin
            send_idle_pct = 14;
            recv_idle_pct = 55;
         end else if (s < 10) begin
            send_idle_pct = 55;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         requests = 50;
         case (s)
            3: begin
               width_data  = CSR_DATA_W'(20000);
               height_data = CSR_DATA_W'(3);
               requests    = 40;
            end
            5: begin
               width_data  = CSR_DATA_W'(1);
               height_data = CSR_DATA_W'(1);
            end
            7: begin
               width_data  = 16'hFFFF;
               height_data = 16'hFFFF;
               requests    = 40;
            end
            9: begin
               width_data  = CSR_DATA_W'(3);
               height_data = 16'hFFFF;
            end
            12: begin
               width_data  = CSR_DATA_W'(MAX_LINE_DEFAULT);
               height_data = CSR_DATA_W'(2);
               requests    = 40;
            end
            default: begin
               width_data  = CSR_DATA_W'($urandom_range(9));
               height_data = CSR_DATA_W'($urandom_range(7));
            end
         endcase
         if ($urandom_range(2) == 0) begin
            write_csr(csr_index_type'($urandom_range(255, 2)), CSR_DATA_W'($urandom));
         end
         write_csr(CSR_LINE_WIDTH, width_data);
         write_csr(CSR_PAGE_HEIGHT, height_data);
         if (s == 10) hold_req = 1'b1;
         for (int i = 0; i < requests; i++) send_pixel(pick_pixel());
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- serpentine_atkinson_error_diffusion_core.f -----
rtl/saed_pkg.sv
rtl/saed_ram.sv
rtl/serpentine_atkinson_error_diffusion_core.sv
tb/saed_dot_checker.sv
tb/tb_serpentine_atkinson_error_diffusion_core.sv
